### hw/rtl/lpkv_pkg.sv
// Shared types, codes and byte helpers for the linear-probe key/value table.
// No dependencies; imported by lpkv_hash and linear_probe_key_value_table_core.
package lpkv_pkg;

  // Stream and configuration port widths
  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;

  // Request opcodes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_DELETE = 2'd3;

  // Result status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_KEY_LONG = 3'd1;
  localparam logic [2:0] STAT_PAY_LONG = 3'd2;
  localparam logic [2:0] STAT_DUP      = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;
  localparam logic [2:0] STAT_MISS     = 3'd5;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SLOTS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 2'd2;

  localparam logic [6:0] ACTIVE_SLOTS_RST  = 7'd64;
  localparam logic [3:0] KEY_LIMIT_RST     = 4'd8;
  localparam logic [3:0] PAYLOAD_LIMIT_RST = 4'd8;

  // Ones in the leading n bytes (byte 0 is bits 63:56)
  function automatic logic [63:0] lead_mask(input logic [3:0] n);
    logic [63:0] m;
    if (n >= 4'd8) begin
      m = '1;
    end else begin
      m = ~({64{1'b1}} >> {n[2:0], 3'b000});
    end
    return m;
  endfunction

  // Bytes before the first zero byte, looking at no more than width bytes
  function automatic logic [3:0] str_len(input logic [63:0] v, input logic [3:0] width);
    logic [3:0] lim;
    logic [3:0] len;
    logic       stop;
    lim  = (width > 4'd8) ? 4'd8 : width;
    len  = lim;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!stop && (4'(i) < lim) && (v[63-8*i -: 8] == 8'd0)) begin
        len  = 4'(i);
        stop = 1'b1;
      end
    end
    return len;
  endfunction

endpackage

### hw/rtl/lpkv_hash.sv
// Start-slot hash: byte sum of the key string, reduced modulo SLOT_COUNT by a
// reciprocal multiplication; sum, quotient and remainder are registered in turn. Uses lpkv_pkg.
module lpkv_hash #(
  parameter int SLOT_COUNT = 64,
  parameter int KEY_BYTES  = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [63:0]                       key_i,
  input  logic [$clog2(SLOT_COUNT+1)-1:0]   active_i,
  output logic                              done_o,
  output logic [$clog2(SLOT_COUNT)-1:0]     slot_o
);
  import lpkv_pkg::*;

  localparam int IW  = $clog2(SLOT_COUNT);
  localparam int CW  = $clog2(SLOT_COUNT + 1);
  localparam int SW  = $clog2(KEY_BYTES * 255 + 1);
  localparam int SH  = SW + IW;
  localparam int MUL = ((1 << SH) + SLOT_COUNT - 1) / SLOT_COUNT;
  localparam int MW  = $clog2(MUL + 1);
  localparam int PRW = SW + MW;

  logic [63:0]    key_str;
  logic [SW-1:0]  sum;
  logic [SW-1:0]  sum_q;
  logic [PRW-1:0] prod;
  logic [SW-1:0]  quo_q;
  logic [31:0]    back;
  logic [IW-1:0]  rem_q;
  logic [2:0]     stage_q;

  assign key_str = key_i & lead_mask(str_len(key_i, 4'(KEY_BYTES)));

  always_comb begin
    sum = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      sum = sum + SW'(key_str[63-8*i -: 8]);
    end
  end

  // Quotient by the rounded-up reciprocal is exact for every sum below 2**SW
  assign prod = PRW'(sum_q) * PRW'(MUL);
  assign back = 32'(quo_q) * 32'(SLOT_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= {stage_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q <= sum;
    end
    if (stage_q[0]) begin
      quo_q <= SW'(prod >> SH);
    end
    if (stage_q[1]) begin
      rem_q <= IW'(32'(sum_q) - back);
    end
  end

  assign done_o = stage_q[2];
  // Start beyond the active range falls back to slot 0
  assign slot_o = (CW'(rem_q) < active_i) ? rem_q : '0;

endmodule

### hw/rtl/linear_probe_key_value_table_core.sv
// Linear-probe key/value table: top level with slot memories and probe sequencer.
// Depends on lpkv_pkg and lpkv_hash.
//
// One request at a time is processed, each giving exactly one result transfer.
// After reset the block sweeps both slot memories to zero, one slot per cycle,
// and holds s_axis_tready low until done. A request that fails a length check goes
// from the accepting cycle straight to loading the result. Any other request is
// accepted, runs the start-slot hash, probes slots one after another from the
// start slot, up to active_slots of them, and then loads the result; the load
// waits while the master side stalls.
// The probe rate is set by the single read port of the key and payload memories,
// which are read together once per slot. A new request is taken while the
// previous result still waits on the master side.
module linear_probe_key_value_table_core #(
  parameter int SLOT_COUNT    = 64,
  parameter int KEY_BYTES     = 8,
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [1:0] opcode, [65:2] key_bytes, [69:66] key_len, [133:70] payload_bytes,
  // [137:134] payload_len, [143:138] zero fill
  input  logic [lpkv_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] status, [66:3] found_payload, [70:67] found_payload_len, [71] zero fill
  output logic [lpkv_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [lpkv_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lpkv_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import lpkv_pkg::*;

  localparam int KW = 8 * KEY_BYTES;
  localparam int PW = 8 * PAYLOAD_BYTES;
  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_PROBE  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  // Input unpacking
  logic [1:0]  in_op;
  logic [63:0] in_key;
  logic [3:0]  in_klen;
  logic [63:0] in_pay;
  logic [3:0]  in_plen;
  logic [63:0] in_key_str;
  logic        in_acc;

  assign in_op      = s_axis_tdata[1:0];
  assign in_key     = s_axis_tdata[65:2];
  assign in_klen    = s_axis_tdata[69:66];
  assign in_pay     = s_axis_tdata[133:70];
  assign in_plen    = s_axis_tdata[137:134];
  assign in_key_str = in_key & lead_mask(str_len(in_key, 4'(KEY_BYTES)));

  // Configuration
  logic [6:0]    act_cfg_q;
  logic [3:0]    key_lim_q;
  logic [3:0]    pay_lim_q;
  logic [CW-1:0] act;
  logic [3:0]    klim;
  logic [3:0]    plim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_cfg_q <= ACTIVE_SLOTS_RST;
      key_lim_q <= KEY_LIMIT_RST;
      pay_lim_q <= PAYLOAD_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACTIVE_SLOTS:  act_cfg_q <= cfg_data_i;
        CFG_KEY_LIMIT:     key_lim_q <= cfg_data_i[3:0];
        CFG_PAYLOAD_LIMIT: pay_lim_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign act  = (act_cfg_q == 7'd0) ? CW'(1) :
                ((32'(act_cfg_q) > SLOT_COUNT) ? CW'(SLOT_COUNT) : CW'(act_cfg_q));
  assign klim = (key_lim_q > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_lim_q;
  assign plim = (pay_lim_q > 4'(PAYLOAD_BYTES)) ? 4'(PAYLOAD_BYTES) : pay_lim_q;

  // Length checks on the incoming request
  logic       chk_err;
  logic [2:0] chk_status;

  always_comb begin
    chk_err    = 1'b0;
    chk_status = STAT_OK;
    if ((in_op == OP_INSERT || in_op == OP_GET || in_op == OP_DELETE) && (in_klen > klim)) begin
      chk_err    = 1'b1;
      chk_status = STAT_KEY_LONG;
    end else if ((in_op == OP_INSERT || in_op == OP_UPDATE) && (in_plen > plim)) begin
      chk_err    = 1'b1;
      chk_status = STAT_PAY_LONG;
    end
  end

  // State and request registers
  logic [2:0]    state_q;
  logic [IW-1:0] clr_addr_q;
  logic [1:0]    op_q;
  logic [KW-1:0] key_raw_q;
  logic [KW-1:0] key_str_q;
  logic [PW-1:0] pay_q;
  logic [3:0]    klen_q;
  logic [3:0]    plen_q;
  logic          err_q;
  logic [2:0]    err_status_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Start-slot hash
  logic          hash_done;
  logic [IW-1:0] hash_slot;

  lpkv_hash #(
    .SLOT_COUNT (SLOT_COUNT),
    .KEY_BYTES  (KEY_BYTES)
  ) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc && !chk_err),
    .key_i    (in_key),
    .active_i (act),
    .done_o   (hash_done),
    .slot_o   (hash_slot)
  );

  // Slot memories
  logic [KW-1:0] key_mem [SLOT_COUNT];
  logic [PW-1:0] pay_mem [SLOT_COUNT];
  logic [KW-1:0] rd_key_q;
  logic [PW-1:0] rd_pay_q;
  logic          key_we;
  logic          pay_we;
  logic [IW-1:0] wr_addr;
  logic [KW-1:0] wr_key;
  logic [PW-1:0] wr_pay;

  // Probe sequencer
  logic [IW-1:0] issue_addr_q;
  logic [CW-1:0] issue_cnt_q;
  logic          eval_vld_q;
  logic [IW-1:0] eval_addr_q;
  logic [CW-1:0] eval_cnt_q;
  logic          hit_q;
  logic [IW-1:0] hit_addr_q;
  logic [PW-1:0] hit_pay_q;
  logic          empty_found_q;
  logic [IW-1:0] empty_addr_q;
  logic [KW-1:0] empty_key_q;
  logic [PW-1:0] empty_pay_q;

  logic          issue_go;
  logic          eval_go;
  logic [IW-1:0] next_addr;
  logic [63:0]   rd_key_al;
  logic          eval_match;
  logic          eval_empty;
  logic          eval_last;

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (pay_we) begin
      pay_mem[wr_addr] <= wr_pay;
    end
    rd_key_q <= key_mem[issue_addr_q];
    rd_pay_q <= pay_mem[issue_addr_q];
  end

  assign issue_go   = (state_q == S_PROBE) && (issue_cnt_q < act);
  assign eval_go    = (state_q == S_PROBE) && eval_vld_q;
  assign next_addr  = ((CW'(issue_addr_q) + CW'(1)) >= act) ? '0 : issue_addr_q + IW'(1);
  assign rd_key_al  = 64'(rd_key_q) << (64 - KW);
  assign eval_match = ((rd_key_al & lead_mask(str_len(rd_key_al, 4'(KEY_BYTES))))
                       == (64'(key_str_q) << (64 - KW)));
  assign eval_empty = (rd_key_q[KW-1 -: 8] == 8'd0);
  assign eval_last  = ((eval_cnt_q + CW'(1)) == act);

  // Output register
  logic          out_load;
  logic          out_valid_q;
  logic [2:0]    out_status_q;
  logic [63:0]   out_pay_q;
  logic [3:0]    out_plen_q;
  logic [2:0]    res_status;
  logic [63:0]   res_pay;
  logic [3:0]    res_plen;

  assign out_load = (state_q == S_RESULT) && (!out_valid_q || m_axis_tready);

  // Byte masks for partial writes
  logic [63:0]   kmask64;
  logic [63:0]   pmask64;
  logic [KW-1:0] kmask;
  logic [PW-1:0] pmask;

  assign kmask64 = lead_mask(klen_q);
  assign pmask64 = lead_mask(plen_q);
  assign kmask   = kmask64[63 -: KW];
  assign pmask   = pmask64[63 -: PW];

  always_comb begin
    key_we     = 1'b0;
    pay_we     = 1'b0;
    wr_addr    = hit_addr_q;
    wr_key     = '0;
    wr_pay     = '0;
    res_status = STAT_OK;
    res_pay    = '0;
    res_plen   = '0;
    if (state_q == S_CLEAR) begin
      key_we  = 1'b1;
      pay_we  = 1'b1;
      wr_addr = clr_addr_q;
    end else if (state_q == S_RESULT) begin
      if (err_q) begin
        res_status = err_status_q;
      end else begin
        case (op_q)
          OP_INSERT: begin
            if (hit_q) begin
              res_status = STAT_DUP;
            end else if (empty_found_q) begin
              key_we  = out_load;
              pay_we  = out_load;
              wr_addr = empty_addr_q;
              wr_key  = (empty_key_q & ~kmask) | (key_raw_q & kmask);
              wr_pay  = (empty_pay_q & ~pmask) | (pay_q & pmask);
            end else begin
              res_status = STAT_FULL;
            end
          end
          OP_GET: begin
            if (hit_q) begin
              res_pay  = 64'(hit_pay_q) << (64 - PW);
              res_plen = str_len(res_pay, 4'(PAYLOAD_BYTES)) + 4'd1;
            end else begin
              res_status = STAT_MISS;
            end
          end
          OP_UPDATE: begin
            if (hit_q) begin
              pay_we = out_load;
              wr_pay = (hit_pay_q & ~pmask) | (pay_q & pmask);
            end else begin
              res_status = STAT_MISS;
            end
          end
          OP_DELETE: begin
            if (hit_q) begin
              key_we = out_load;
              pay_we = out_load;
            end else begin
              res_status = STAT_MISS;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_addr_q    <= '0;
      issue_cnt_q   <= '0;
      eval_vld_q    <= 1'b0;
      eval_cnt_q    <= '0;
      hit_q         <= 1'b0;
      empty_found_q <= 1'b0;
      err_q         <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          clr_addr_q <= clr_addr_q + IW'(1);
          if (clr_addr_q == IW'(SLOT_COUNT - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            err_q   <= chk_err;
            state_q <= chk_err ? S_RESULT : S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            issue_cnt_q   <= '0;
            eval_vld_q    <= 1'b0;
            eval_cnt_q    <= '0;
            hit_q         <= 1'b0;
            empty_found_q <= 1'b0;
            state_q       <= S_PROBE;
          end
        end
        S_PROBE: begin
          eval_vld_q <= issue_go;
          if (issue_go) begin
            issue_cnt_q <= issue_cnt_q + CW'(1);
          end
          if (eval_go) begin
            if (eval_match) begin
              hit_q   <= 1'b1;
              state_q <= S_RESULT;
            end else begin
              if (eval_empty) begin
                empty_found_q <= 1'b1;
              end
              eval_cnt_q <= eval_cnt_q + CW'(1);
              if (eval_last) begin
                state_q <= S_RESULT;
              end
            end
          end
        end
        S_RESULT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Request and probe data registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q         <= in_op;
      key_raw_q    <= in_key[63 -: KW];
      key_str_q    <= in_key_str[63 -: KW];
      pay_q        <= in_pay[63 -: PW];
      klen_q       <= in_klen;
      plen_q       <= in_plen;
      err_status_q <= chk_status;
    end
    if ((state_q == S_HASH) && hash_done) begin
      issue_addr_q <= hash_slot;
    end else if (issue_go) begin
      issue_addr_q <= next_addr;
      eval_addr_q  <= issue_addr_q;
    end
    if (eval_go && eval_match) begin
      hit_addr_q <= eval_addr_q;
      hit_pay_q  <= rd_pay_q;
    end
    // Keep the first empty slot in probe order for placement
    if (eval_go && !eval_match && eval_empty && !empty_found_q) begin
      empty_addr_q <= eval_addr_q;
      empty_key_q  <= rd_key_q;
      empty_pay_q  <= rd_pay_q;
    end
  end

  // Result transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status;
      out_pay_q    <= res_pay;
      out_plen_q   <= res_plen;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_plen_q, out_pay_q, out_status_q};

`ifndef SYNTH
  a_no_write_in_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> !(key_we || pay_we))
    else $error("slot memory written during probe");

  a_eval_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_go |-> (eval_cnt_q < act) && (eval_cnt_q < issue_cnt_q))
    else $error("probe evaluated beyond the active slots");

  a_result_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (state_q == S_IDLE) && out_valid_q)
    else $error("result load did not return to idle");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_HASH || state_q == S_RESULT))
    else $error("accepted request did not start");
`endif

endmodule

### tb/tb_linear_probe_key_value_table_core.sv
// Self-checking testbench for linear_probe_key_value_table_core: directed table then random
// requests over several register settings, each result checked against a slot-table predictor
// or a directed step's own expectation. Depends on lpkv_pkg and the core RTL only.
module tb_linear_probe_key_value_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lpkv_pkg::*;

  localparam int NUM_SLOTS     = 64;
  localparam int CYCLE_LIMIT   = 800_000;
  localparam int PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int POOL_SIZE     = 10;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [3:0]  klen;
    logic [63:0] pay;
    logic [3:0]  plen;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] payload;
    logic [3:0]  plen;
  } reply_t;

  typedef struct {
    req_t   req;
    bit     typed;
    reply_t want;
  } step_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  linear_probe_key_value_table_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state: slot contents and register copies
  logic [63:0] table_key [NUM_SLOTS];
  logic [63:0] table_pay [NUM_SLOTS];
  logic [6:0]  cfg_active  = ACTIVE_SLOTS_RST;
  logic [3:0]  cfg_key_lim = KEY_LIMIT_RST;
  logic [3:0]  cfg_pay_lim = PAYLOAD_LIMIT_RST;

  // Register settings for the random phases
  logic [6:0]  act_set [PHASES] = '{7'd4, 7'd0, 7'd127, 7'd13, 7'd64, 7'd1};
  logic [6:0]  klim_set [PHASES] = '{7'd8, 7'd15, 7'd0, 7'd3, 7'd8, 7'd1};
  logic [6:0]  plim_set [PHASES] = '{7'd8, 7'd15, 7'd0, 7'd5, 7'd8, 7'd1};

  reply_t replies_due [$];
  step_t  plan [$];
  logic [63:0] key_pool [POOL_SIZE];
  int     err_count = 0;
  int     req_count = 0;
  int     status_seen [6] = '{default: 0};
  int     src_idle_pct = 28;
  int     sink_idle_pct = 81;
  int     cycle_count = 0;

  function automatic logic [63:0] head_mask(input int n);
    if (n <= 0) return 64'd0;
    if (n >= 8) return '1;
    return ~({64{1'b1}} >> (8 * n));
  endfunction

  function automatic int text_len(input logic [63:0] v);
    for (int i = 0; i < 8; i++) begin
      if (v[63-8*i -: 8] == 8'd0) return i;
    end
    return 8;
  endfunction

  function automatic int home_slot(input logic [63:0] ks, input int act);
    int sum;
    sum = 0;
    for (int i = 0; i < 8; i++) sum += ks[63-8*i -: 8];
    sum = sum % NUM_SLOTS;
    return (sum < act) ? sum : 0;
  endfunction

  function automatic int find_slot(input logic [63:0] ks, input int act);
    int k;
    k = home_slot(ks, act);
    for (int n = 0; n < act; n++) begin
      if ((table_key[k] & head_mask(text_len(table_key[k]))) == ks) return k;
      k = (k + 1 >= act) ? 0 : k + 1;
    end
    return -1;
  endfunction

  function automatic reply_t predict_table_op(input req_t r);
    reply_t      res;
    int          act, klim, plim, hit, k;
    logic [63:0] ks;
    bit          placed;
    act  = (cfg_active == 0) ? 1 : ((cfg_active > NUM_SLOTS) ? NUM_SLOTS : int'(cfg_active));
    klim = (cfg_key_lim > 8) ? 8 : int'(cfg_key_lim);
    plim = (cfg_pay_lim > 8) ? 8 : int'(cfg_pay_lim);
    res  = '{STAT_OK, 64'd0, 4'd0};
    ks   = r.key & head_mask(text_len(r.key));
    if (r.op != OP_UPDATE && r.klen > klim) begin
      res.status = STAT_KEY_LONG;
    end else if ((r.op == OP_INSERT || r.op == OP_UPDATE) && r.plen > plim) begin
      res.status = STAT_PAY_LONG;
    end else begin
      hit = find_slot(ks, act);
      if (r.op == OP_INSERT) begin
        if (hit >= 0) begin
          res.status = STAT_DUP;
        end else begin
          k = home_slot(ks, act);
          placed = 1'b0;
          for (int n = 0; n < act && !placed; n++) begin
            if (table_key[k][63:56] == 8'd0) begin
              table_key[k] = (table_key[k] & ~head_mask(r.klen)) | (r.key & head_mask(r.klen));
              table_pay[k] = (table_pay[k] & ~head_mask(r.plen)) | (r.pay & head_mask(r.plen));
              placed = 1'b1;
            end else begin
              k = (k + 1 >= act) ? 0 : k + 1;
            end
          end
          if (!placed) res.status = STAT_FULL;
        end
      end else if (hit < 0) begin
        res.status = STAT_MISS;
      end else begin
        case (r.op)
          OP_GET: begin
            res.payload = table_pay[hit];
            res.plen    = 4'(text_len(table_pay[hit]) + 1);
          end
          OP_UPDATE: begin
            table_pay[hit] = (table_pay[hit] & ~head_mask(r.plen)) | (r.pay & head_mask(r.plen));
          end
          default: begin
            table_key[hit] = 64'd0;
            table_pay[hit] = 64'd0;
          end
        endcase
      end
    end
    return res;
  endfunction

  // Random text: zero to eight nonzero leading bytes, a terminator after fewer than eight, then zeros or junk
  function automatic logic [63:0] rand_text();
    int          n;
    logic [63:0] v;
    n = $urandom_range(0, 8);
    v = {$urandom, $urandom};
    for (int i = 0; i < 8; i++) begin
      if (i < n && v[63-8*i -: 8] == 8'd0) v[63-8*i -: 8] = 8'($urandom_range(1, 255));
      if (i == n) v[63-8*i -: 8] = 8'd0;
    end
    if ($urandom_range(0, 1) == 0) v &= head_mask(n);
    return v;
  endfunction

  function automatic logic [3:0] rand_len(input logic [63:0] v);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 4'((text_len(v) + 1 > 8) ? 8 : text_len(v) + 1);
    if (pick < 85) return 4'($urandom_range(0, 8));
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic void add_step(input logic [1:0] op, input logic [63:0] key,
                                   input logic [3:0] klen, input logic [63:0] pay,
                                   input logic [3:0] plen, input bit typed,
                                   input logic [2:0] st, input logic [63:0] fp,
                                   input logic [3:0] fl);
    step_t s;
    s.req   = '{op, key, klen, pay, plen};
    s.typed = typed;
    s.want  = '{st, fp, fl};
    plan.push_back(s);
  endfunction

  // Present one request, hold it until the transfer, then record its expectation
  task automatic push_request(input req_t r, input bit typed, input reply_t want);
    reply_t pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, r.plen, r.pay, r.klen, r.key, r.op};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = predict_table_op(r);
    replies_due.push_back(typed ? want : pred);
    if (pred.status < 6) status_seen[pred.status]++;
    req_count++;
  endtask

  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_ACTIVE_SLOTS:  cfg_active  = val;
      CFG_KEY_LIMIT:     cfg_key_lim = val[3:0];
      CFG_PAYLOAD_LIMIT: cfg_pay_lim = val[3:0];
      default: ;
    endcase
  endtask

  // Result side: check every transfer, then pick the next ready level
  initial begin
    reply_t got, want;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[2:0], m_axis_tdata[66:3], m_axis_tdata[70:67]};
        if (replies_due.size() == 0) begin
          $display("%0t: result with nothing expected, actual status %0d payload %h len %0d",
                   $time, got.status, got.payload, got.plen);
          err_count++;
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            err_count++;
          end
          if (got.payload !== want.payload) begin
            $display("%0t: found_payload expected %h actual %h", $time, want.payload,
                     got.payload);
            err_count++;
          end
          if (got.plen !== want.plen) begin
            $display("%0t: found_payload_len expected %0d actual %0d", $time, want.plen,
                     got.plen);
            err_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               replies_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    req_t   r;
    reply_t none;
    int     pick;

    none = '{STAT_OK, 64'd0, 4'd0};
    for (int i = 0; i < NUM_SLOTS; i++) begin
      table_key[i] = 64'd0;
      table_pay[i] = 64'd0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table at the reset settings
    add_step(OP_GET,    64'h4100_0000_0000_0000, 4'd2, 64'd0, 4'd0, 1, STAT_MISS, 64'd0, 4'd0);
    add_step(OP_DELETE, 64'h4100_0000_0000_0000, 4'd2, 64'd0, 4'd0, 1, STAT_MISS, 64'd0, 4'd0);
    add_step(OP_UPDATE, 64'h4100_0000_0000_0000, 4'd2, 64'h7700_0000_0000_0000, 4'd1,
             1, STAT_MISS, 64'd0, 4'd0);
    add_step(OP_INSERT, 64'h4142_4300_0000_0000, 4'd9, 64'd0, 4'd0,
             1, STAT_KEY_LONG, 64'd0, 4'd0);
    add_step(OP_INSERT, 64'h4142_4300_0000_0000, 4'd15, 64'd0, 4'd15,
             1, STAT_KEY_LONG, 64'd0, 4'd0);
    add_step(OP_INSERT, 64'h4142_4300_0000_0000, 4'd8, 64'd0, 4'd9,
             1, STAT_PAY_LONG, 64'd0, 4'd0);
    add_step(OP_INSERT, 64'h4142_0000_0000_0000, 4'd3, '1, 4'd8, 1, STAT_OK, 64'd0, 4'd0);
    add_step(OP_INSERT, 64'h4142_0000_0000_0000, 4'd3, 64'd0, 4'd1, 1, STAT_DUP, 64'd0, 4'd0);
    add_step(OP_GET,    64'h4142_0000_0000_0000, 4'd3, 64'd0, 4'd0, 1, STAT_OK, '1, 4'd9);
    add_step(OP_UPDATE, 64'h4142_0000_0000_0000, 4'd3, 64'h1100_5500_0000_0000, 4'd2,
             0, STAT_OK, 64'd0, 4'd0);
    add_step(OP_GET,    64'h4142_0000_0000_0000, 4'd3, 64'd0, 4'd0, 0, STAT_OK, 64'd0, 4'd0);
    add_step(OP_UPDATE, 64'h4142_0000_0000_0000, 4'd3, 64'd0, 4'd9,
             1, STAT_PAY_LONG, 64'd0, 4'd0);
    add_step(OP_UPDATE, 64'h4142_0000_0000_0000, 4'd15, 64'h2233_4455_6677_8899, 4'd1,
             0, STAT_OK, 64'd0, 4'd0);
    add_step(OP_GET,    64'h4142_0000_0000_0000, 4'd15, 64'd0, 4'd0,
             1, STAT_KEY_LONG, 64'd0, 4'd0);
    add_step(OP_INSERT, '1, 4'd8, 64'd0, 4'd0, 0, STAT_OK, 64'd0, 4'd0);
    add_step(OP_GET,    '1, 4'd8, 64'd0, 4'd0, 0, STAT_OK, 64'd0, 4'd0);
    add_step(OP_INSERT, 64'h4100_42FF_0000_0001, 4'd8, 64'h00AB_CDEF_0000_0000, 4'd8,
             0, STAT_OK, 64'd0, 4'd0);
    add_step(OP_GET,    64'h4100_0000_0000_0000, 4'd0, 64'd0, 4'd0, 0, STAT_OK, 64'd0, 4'd0);
    add_step(OP_DELETE, 64'h4142_0000_0000_0000, 4'd3, 64'd0, 4'd0, 0, STAT_OK, 64'd0, 4'd0);
    add_step(OP_GET,    64'h4142_0000_0000_0000, 4'd3, 64'd0, 4'd0, 0, STAT_OK, 64'd0, 4'd0);
    add_step(OP_INSERT, 64'd0, 4'd0, 64'd0, 4'd0, 0, STAT_OK, 64'd0, 4'd0);
    add_step(OP_INSERT, 64'h5A00_0000_0000_0000, 4'd0, 64'h1234_0000_0000_0000, 4'd0,
             0, STAT_OK, 64'd0, 4'd0);
    add_step(OP_GET,    64'h5A00_0000_0000_0000, 4'd2, 64'd0, 4'd0, 0, STAT_OK, 64'd0, 4'd0);
    add_step(OP_DELETE, '1, 4'd8, 64'd0, 4'd0, 0, STAT_OK, 64'd0, 4'd0);
    foreach (plan[i]) push_request(plan[i].req, plan[i].typed, plan[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain_replies();
      write_reg(CFG_ACTIVE_SLOTS, act_set[p]);
      write_reg(CFG_KEY_LIMIT, klim_set[p]);
      write_reg(CFG_PAYLOAD_LIMIT, plim_set[p]);
      cfg_we_i <= 1'b0;
      src_idle_pct  = (p < 2) ? 28 : ((p < 4) ? 81 : 0);
      sink_idle_pct = (p < 2) ? 81 : ((p < 4) ? 28 : 0);
      // A small key pool per phase so that hits, duplicates and a full table occur
      foreach (key_pool[i]) key_pool[i] = rand_text();
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 99);
        r.op = (pick < 35) ? OP_INSERT : (pick < 65) ? OP_GET : (pick < 80) ? OP_UPDATE
                                                                            : OP_DELETE;
        r.key  = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                             : {$urandom, $urandom};
        r.klen = rand_len(r.key);
        r.pay  = rand_text();
        r.plen = rand_len(r.pay);
        push_request(r, 1'b0, none);
      end
    end

    drain_replies();
    repeat (100) @(posedge clk_i);
    if (replies_due.size() != 0) err_count++;
    $display("%0d requests over %0d register settings, with and without stalls", req_count,
             PHASES + 1);
    $display("status mix: ok %0d, key long %0d, payload long %0d, dup %0d, full %0d, miss %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4],
             status_seen[5]);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/lpkv_pkg.sv
hw/rtl/lpkv_hash.sv
hw/rtl/linear_probe_key_value_table_core.sv
tb/tb_linear_probe_key_value_table_core.sv
